### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the thrust and mass step block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hdl/rmt_pkg.sv
// Shared constants and helper functions of the thrust and mass step block.
`default_nettype none
package rmt_pkg;

  // Field widths.
  localparam int STEP_W     = 20;
  localparam int TIME_W     = 40;
  localparam int VEL_W      = 32;
  localparam int ANG_W      = 16;
  localparam int MASS_W     = 40;
  localparam int THR_W      = 25;
  localparam int FORCE_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Internal arithmetic widths.
  localparam int DIV_NUM_W  = 56;
  localparam int DIV_DEN_W  = 32;
  localparam int SQ_RAD_W   = 64;
  localparam int SQ_ROOT_W  = 32;
  localparam int CORD_W     = 34;
  localparam int CORD_ITERS = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_FLOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_FLOW = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 4'd7;

  // CORDIC start value (inverse gain in Q30) and thrust clamp.
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [THR_W-1:0]  THRUST_LIMIT = 25'sd16777215;

  // Arctangent of 2^-i in units where 2^32 is a full turn.
  function automatic logic [31:0] atan_unit(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/rmt_if.sv
// Handshake channel interfaces: step request, step result and configuration write.
`default_nettype none
interface rmt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rmt_pkg::STEP_W-1:0]    sim_step;
  logic        [rmt_pkg::TIME_W-1:0]    fly_time;
  logic signed [rmt_pkg::VEL_W-1:0]     vel_x;
  logic signed [rmt_pkg::VEL_W-1:0]     vel_y;
  logic signed [rmt_pkg::VEL_W-1:0]     vel_z;
  logic signed [rmt_pkg::ANG_W-1:0]     angle_x;
  logic signed [rmt_pkg::ANG_W-1:0]     angle_y;
  logic signed [rmt_pkg::ANG_W-1:0]     angle_z;
  modport source (output valid, sim_step, fly_time, vel_x, vel_y, vel_z,
                  angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, sim_step, fly_time, vel_x, vel_y, vel_z,
                angle_x, angle_y, angle_z, output ready);
endinterface

interface rmt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rmt_pkg::MASS_W-1:0]    mass_left;
  logic signed [rmt_pkg::THR_W-1:0]     thrust_x;
  logic signed [rmt_pkg::THR_W-1:0]     thrust_y;
  logic signed [rmt_pkg::THR_W-1:0]     thrust_z;
  modport source (output valid, mass_left, thrust_x, thrust_y, thrust_z, input ready);
  modport sink (input valid, mass_left, thrust_x, thrust_y, thrust_z, output ready);
endinterface

interface rmt_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rmt_pkg::CFG_IDX_W-1:0]        index;
  logic [rmt_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/rmt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rmt_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rmt_pkg::DIV_NUM_W-1:0] numer,
  input  wire logic [rmt_pkg::DIV_DEN_W-1:0] denom,
  output logic                               done,
  output logic      [rmt_pkg::DIV_NUM_W-1:0] quot
);
  import rmt_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  // Trial subtraction of the divisor from the partial remainder.
  assign shifted = {rem, num[DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign quot    = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W - 1);
        rem  <= '0;
        den  <= denom;
        num  <= numer;
      end else if (busy) begin
        rem <= fits ? DIV_DEN_W'(shifted - {1'b0, den}) : shifted[DIV_DEN_W-1:0];
        num <= {num[DIV_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/rmt_isqrt.sv
// Integer square root, two radicand bits and one root bit per cycle.
`default_nettype none
module rmt_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rmt_pkg::SQ_RAD_W-1:0]  radicand,
  output logic                               done,
  output logic      [rmt_pkg::SQ_ROOT_W-1:0] root
);
  import rmt_pkg::*;

  localparam int CNT_W = $clog2(SQ_ROOT_W);
  localparam int REM_W = SQ_ROOT_W + 3;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [SQ_RAD_W-1:0]  rad;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     rem2;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  // Bring down the next bit pair and test the candidate root bit.
  assign rem2  = {rem[REM_W-3:0], rad[SQ_RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SQ_ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= fits ? rem2 - trial : rem2;
        root <= {root[SQ_ROOT_W-2:0], fits};
        rad  <= {rad[SQ_RAD_W-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/rmt_cordic.sv
// Rotation-mode CORDIC for cosine and sine in Q30, one iteration per cycle.
`default_nettype none
module rmt_cordic (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic        [rmt_pkg::ANG_W-1:0]  angle,
  output logic                                   done,
  output logic signed      [rmt_pkg::CORD_W-1:0] cos_out,
  output logic signed      [rmt_pkg::CORD_W-1:0] sin_out
);
  import rmt_pkg::*;

  localparam int IT_W = $clog2(CORD_ITERS);
  localparam logic signed [CORD_W-1:0] QUARTER = 34'sh0_4000_0000;

  logic                     busy;
  logic                     flip;
  logic [IT_W-1:0]          iter;
  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [CORD_W-1:0] z;
  logic [31:0]              a_raw;
  logic signed [CORD_W-1:0] z_raw;
  logic signed [CORD_W-1:0] z_flip;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] step_ang;

  // Angles beyond a quarter turn are rotated by a half turn first.
  assign a_raw    = {angle, 16'h0000};
  assign z_raw    = CORD_W'(signed'(a_raw));
  assign z_flip   = CORD_W'(signed'(a_raw ^ 32'h8000_0000));
  assign xs       = x >>> iter;
  assign ys       = y >>> iter;
  assign step_ang = signed'({2'b00, atan_unit(iter)});
  assign cos_out  = flip ? -x : x;
  assign sin_out  = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        if (z_raw > QUARTER || z_raw < -QUARTER) begin
          flip <= 1'b1;
          z    <= z_flip;
        end else begin
          flip <= 1'b0;
          z    <= z_raw;
        end
      end else if (busy) begin
        if (!z[CORD_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - step_ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + step_ang;
        end
        iter <= iter + 1'b1;
        if (iter == IT_W'(CORD_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/rocket_motor_thrust_mass_step.sv
// Top level: step sequencer with a shared multiplier, divider, square root and CORDIC.
// One step request at a time: a request is taken, worked through by a sequencer that
// drives one registered 34x34 multiplier, a restoring divider (ramp phases), a square
// root (speed-hold phase) and a 16-iteration CORDIC run three times, then the result
// is placed in an output register. The input is ready again as soon as the result is
// registered, even while it waits to be taken.
// Configuration writes are always accepted and must only be made while idle.
`default_nettype none
`include "assert_macros.svh"
module rocket_motor_thrust_mass_step #(
  parameter logic [39:0] INITIAL_MASS_MG = 40'd100000000
) (
  input wire logic  clk,
  input wire logic  rst,
  rmt_in_if.sink    step_in,
  rmt_out_if.source step_out,
  rmt_cfg_if.sink   cfg
);
  import rmt_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
  localparam logic [ST_W-1:0] S_EDGE   = 5'd1;
  localparam logic [ST_W-1:0] S_PHASE  = 5'd2;
  localparam logic [ST_W-1:0] S_NUM    = 5'd3;
  localparam logic [ST_W-1:0] S_DIVGO  = 5'd4;
  localparam logic [ST_W-1:0] S_DIVW   = 5'd5;
  localparam logic [ST_W-1:0] S_SQ     = 5'd6;
  localparam logic [ST_W-1:0] S_ACC    = 5'd7;
  localparam logic [ST_W-1:0] S_SQRTGO = 5'd8;
  localparam logic [ST_W-1:0] S_SQRTW  = 5'd9;
  localparam logic [ST_W-1:0] S_FCHK   = 5'd10;
  localparam logic [ST_W-1:0] S_FLOW   = 5'd11;
  localparam logic [ST_W-1:0] S_HI     = 5'd12;
  localparam logic [ST_W-1:0] S_LO     = 5'd13;
  localparam logic [ST_W-1:0] S_MASS   = 5'd14;
  localparam logic [ST_W-1:0] S_CGO    = 5'd15;
  localparam logic [ST_W-1:0] S_CW     = 5'd16;
  localparam logic [ST_W-1:0] S_TP     = 5'd17;
  localparam logic [ST_W-1:0] S_TQ     = 5'd18;
  localparam logic [ST_W-1:0] S_TF     = 5'd19;
  localparam logic [ST_W-1:0] S_TR     = 5'd20;
  localparam logic [ST_W-1:0] S_OUT    = 5'd21;

  localparam logic [1:0] PH_UP    = 2'd0;
  localparam logic [1:0] PH_HOLD  = 2'd1;
  localparam logic [1:0] PH_DOWN  = 2'd2;
  localparam logic [1:0] PH_SPEED = 2'd3;

  localparam int MQ_W  = MASS_W + 16;
  localparam int MUL_W = CORD_W;
  localparam int PRD_W = 2 * MUL_W;

  // Configuration registers.
  logic [31:0]        ramp_up_time;
  logic [31:0]        hold_time;
  logic [31:0]        ramp_down_time;
  logic [FORCE_W-1:0] boost_thrust;
  logic [FORCE_W-1:0] sustain_thrust_max;
  logic [31:0]        boost_flow;
  logic [31:0]        sustain_flow;
  logic [31:0]        target_speed;

  // Captured request and working registers.
  logic [ST_W-1:0]          state;
  logic [1:0]               phase;
  logic [1:0]               idx;
  logic [STEP_W-1:0]        sim_step;
  logic [TIME_W-1:0]        fly_time;
  logic signed [VEL_W-1:0]  vel [3];
  logic [ANG_W-1:0]         ang [3];
  logic [32:0]              t2;
  logic [33:0]              t3;
  logic                     diff_neg;
  logic [FORCE_W-1:0]       diff_mag;
  logic [FORCE_W-1:0]       f;
  logic [SQ_RAD_W-1:0]      sum_sq;
  logic [31:0]              plo;
  logic [43:0]              dm_hi;
  logic [MQ_W-1:0]          mass;
  logic signed [CORD_W-1:0] cx;
  logic signed [CORD_W-1:0] cy;
  logic signed [CORD_W-1:0] sy;
  logic signed [CORD_W-1:0] sz;
  logic signed [CORD_W-1:0] qsum;
  logic signed [CORD_W-1:0] pq;
  logic signed [THR_W-1:0]  thr [3];
  logic                     out_valid;
  logic [MASS_W-1:0]        out_mass;
  logic signed [THR_W-1:0]  out_thr [3];

  // Shared multiplier operands and registered product.
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PRD_W-1:0] prod;

  // Helper nets.
  logic [32:0]              vabs;
  logic [31:0]              tdiff;
  logic [24:0]              diff;
  logic [25:0]              down_f;
  logic signed [33:0]       err;
  logic [60:0]              dm;
  logic signed [36:0]       thr_raw;
  logic [DIV_NUM_W-1:0]     quot;
  logic                     div_done;
  logic [SQ_ROOT_W-1:0]     root;
  logic                     sqrt_done;
  logic                     cord_done;
  logic signed [CORD_W-1:0] cord_cos;
  logic signed [CORD_W-1:0] cord_sin;
  logic                     accept;

  assign accept   = step_in.valid && step_in.ready;
  assign step_in.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  assign step_out.valid     = out_valid;
  assign step_out.mass_left = out_mass;
  assign step_out.thrust_x  = out_thr[0];
  assign step_out.thrust_y  = out_thr[1];
  assign step_out.thrust_z  = out_thr[2];

  // Derived values for the ramp and speed-hold arithmetic.
  assign vabs   = vel[idx][VEL_W-1] ? 33'd0 - {vel[idx][VEL_W-1], vel[idx]}
                                    : {1'b0, vel[idx]};
  assign tdiff  = fly_time[31:0] - t2[31:0];
  assign diff   = {1'b0, sustain_thrust_max} - {1'b0, boost_thrust};
  assign down_f = diff_neg ? {2'b00, boost_thrust} - {2'b00, quot[FORCE_W-1:0]}
                           : {2'b00, boost_thrust} + {2'b00, quot[FORCE_W-1:0]};
  assign err    = signed'({2'b00, target_speed}) - signed'({2'b00, root});
  assign dm     = {1'b0, dm_hi, 16'h0000} + {25'd0, prod[51:16]};
  assign thr_raw = prod[PRD_W-1:31];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NUM: begin
        if (phase == PH_UP) begin
          mul_a = signed'({10'd0, boost_thrust});
          mul_b = signed'({2'b00, fly_time[31:0]});
        end else begin
          mul_a = signed'({10'd0, diff_mag});
          mul_b = signed'({2'b00, tdiff});
        end
      end
      S_SQ: begin
        mul_a = signed'({1'b0, vabs});
        mul_b = signed'({1'b0, vabs});
      end
      S_FLOW: begin
        mul_a = signed'({10'd0, f});
        mul_b = signed'({2'b00, (phase == PH_SPEED) ? sustain_flow : boost_flow});
      end
      S_HI: begin
        mul_a = signed'({10'd0, prod[55:32]});
        mul_b = signed'({14'd0, sim_step});
      end
      S_LO: begin
        mul_a = signed'({2'b00, plo});
        mul_b = signed'({14'd0, sim_step});
      end
      S_TP: begin
        mul_a = cx;
        case (idx)
          2'd0:    mul_b = qsum;
          2'd1:    mul_b = sy;
          default: mul_b = sz;
        endcase
      end
      S_TF: begin
        mul_a = signed'({10'd0, f});
        mul_b = pq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_up_time       <= 32'd1000000;
      hold_time          <= 32'd5000000;
      ramp_down_time     <= 32'd1000000;
      boost_thrust       <= 24'd10000;
      sustain_thrust_max <= 24'd2000;
      boost_flow         <= 32'd17530000;
      sustain_flow       <= 32'd17530000;
      target_speed       <= 32'd340000;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RAMP_UP:      ramp_up_time       <= cfg.data;
        REG_HOLD:         hold_time          <= cfg.data;
        REG_RAMP_DOWN:    ramp_down_time     <= cfg.data;
        REG_BOOST:        boost_thrust       <= cfg.data[FORCE_W-1:0];
        REG_SUSTAIN:      sustain_thrust_max <= cfg.data[FORCE_W-1:0];
        REG_BOOST_FLOW:   boost_flow         <= cfg.data;
        REG_SUSTAIN_FLOW: sustain_flow       <= cfg.data;
        REG_TARGET:       target_speed       <= cfg.data;
        default: ;
      endcase
    end
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mass      <= {INITIAL_MASS_MG, 16'h0000};
    end else begin
      // The output register is emptied when taken, unless it is refilled this cycle.
      if (out_valid && step_out.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sim_step <= step_in.sim_step;
            fly_time <= step_in.fly_time;
            vel[0]   <= step_in.vel_x;
            vel[1]   <= step_in.vel_y;
            vel[2]   <= step_in.vel_z;
            ang[0]   <= step_in.angle_x;
            ang[1]   <= step_in.angle_y;
            ang[2]   <= step_in.angle_z;
            state    <= S_EDGE;
          end
        end
        S_EDGE: begin
          t2    <= {1'b0, ramp_up_time} + {1'b0, hold_time};
          t3    <= {2'b00, ramp_up_time} + {2'b00, hold_time} + {2'b00, ramp_down_time};
          state <= S_PHASE;
        end
        S_PHASE: begin
          diff_neg <= diff[24];
          diff_mag <= diff[24] ? FORCE_W'(25'd0 - diff) : diff[FORCE_W-1:0];
          idx      <= 2'd0;
          sum_sq   <= '0;
          if (fly_time < {8'd0, ramp_up_time}) begin
            phase <= PH_UP;
            state <= S_NUM;
          end else if (fly_time < {7'd0, t2}) begin
            phase <= PH_HOLD;
            f     <= boost_thrust;
            state <= S_FCHK;
          end else if (fly_time < {6'd0, t3}) begin
            phase <= PH_DOWN;
            state <= S_NUM;
          end else begin
            phase <= PH_SPEED;
            state <= S_SQ;
          end
        end
        S_NUM:   state <= S_DIVGO;
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            f     <= (phase == PH_UP) ? quot[FORCE_W-1:0] : down_f[FORCE_W-1:0];
            state <= S_FCHK;
          end
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          sum_sq <= sum_sq + prod[SQ_RAD_W-1:0];
          if (idx == 2'd2) begin
            state <= S_SQRTGO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ;
          end
        end
        S_SQRTGO: state <= S_SQRTW;
        S_SQRTW: begin
          if (sqrt_done) begin
            if (err < 0) begin
              f <= '0;
            end else if (err > signed'({10'd0, sustain_thrust_max})) begin
              f <= sustain_thrust_max;
            end else begin
              f <= err[FORCE_W-1:0];
            end
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          // A spent motor gives no thrust.
          if (mass == '0) begin
            f <= '0;
          end
          state <= S_FLOW;
        end
        S_FLOW: state <= S_HI;
        S_HI: begin
          plo   <= prod[31:0];
          state <= S_LO;
        end
        S_LO: begin
          dm_hi <= prod[43:0];
          state <= S_MASS;
        end
        S_MASS: begin
          // Mass saturates at zero when the decrement exceeds it.
          mass  <= ({5'd0, mass} > dm) ? mass - dm[MQ_W-1:0] : '0;
          idx   <= 2'd0;
          state <= S_CGO;
        end
        S_CGO: state <= S_CW;
        S_CW: begin
          if (cord_done) begin
            case (idx)
              2'd0: cx <= cord_cos;
              2'd1: begin
                cy <= cord_cos;
                sy <= cord_sin;
              end
              default: begin
                qsum <= cy + cord_cos;
                sz   <= cord_sin;
              end
            endcase
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              state <= S_TP;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_CGO;
            end
          end
        end
        S_TP: state <= S_TQ;
        S_TQ: begin
          pq    <= prod[63:30];
          state <= S_TF;
        end
        S_TF: state <= S_TR;
        S_TR: begin
          if (thr_raw > 37'(THRUST_LIMIT)) begin
            thr[idx] <= THRUST_LIMIT;
          end else if (thr_raw < -37'(THRUST_LIMIT)) begin
            thr[idx] <= -THRUST_LIMIT;
          end else begin
            thr[idx] <= thr_raw[THR_W-1:0];
          end
          if (idx == 2'd2) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TP;
          end
        end
        S_OUT: begin
          if (!out_valid || step_out.ready) begin
            out_valid  <= 1'b1;
            out_mass   <= mass[MQ_W-1:16];
            out_thr[0] <= thr[0];
            out_thr[1] <= thr[1];
            out_thr[2] <= thr[2];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Shared iterative units.
  rmt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVGO),
    .numer (prod[DIV_NUM_W-1:0]),
    .denom ((phase == PH_UP) ? ramp_up_time : ramp_down_time),
    .done  (div_done),
    .quot  (quot)
  );

  rmt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQRTGO),
    .radicand (sum_sq),
    .done     (sqrt_done),
    .root     (root)
  );

  rmt_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_CGO),
    .angle   (ang[idx]),
    .done    (cord_done),
    .cos_out (cord_cos),
    .sin_out (cord_sin)
  );

  // Checks on the sequencer and datapath.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, accept, !step_in.ready)
  `ASSERT_NEXT(a_mass_no_rise, clk, rst, 1'b1, mass <= $past(mass))
  `ASSERT_HOLDS(a_thrust_bounded, clk, rst, state == S_OUT, thr[0] <= THRUST_LIMIT && thr[0] >= -THRUST_LIMIT)

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the rocket motor thrust and mass step block.
`timescale 1ns / 1ps

typedef struct {
  logic [19:0]        sim_step;
  logic [39:0]        fly_time;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic signed [15:0] angle_x, angle_y, angle_z;
} step_req_t;

typedef struct {
  logic [39:0]        mass_left;
  logic signed [24:0] thrust_x, thrust_y, thrust_z;
} motor_out_t;

// Tracks the motor state, predicts each step result and compares it with the block.
class motor_scoreboard;
  bit [31:0]  ramp_up, hold, ramp_down, boost_flow, sustain_flow, target;
  bit [23:0]  boost, sustain;
  bit [63:0]  mass_q16;
  motor_out_t expected_q[$];
  int         errors;
  int         checked;
  int         spent_steps;
  bit [31:0]  atan_tab[16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  function new();
    ramp_up = 1000000; hold = 5000000; ramp_down = 1000000;
    boost = 10000; sustain = 2000;
    boost_flow = 17530000; sustain_flow = 17530000; target = 340000;
    mass_q16 = 64'd100000000 << 16;
  endfunction

  function void write_reg(logic [3:0] idx, logic [31:0] d);
    case (idx)
      rmt_pkg::REG_RAMP_UP:      ramp_up = d;
      rmt_pkg::REG_HOLD:         hold = d;
      rmt_pkg::REG_RAMP_DOWN:    ramp_down = d;
      rmt_pkg::REG_BOOST:        boost = d[23:0];
      rmt_pkg::REG_SUSTAIN:      sustain = d[23:0];
      rmt_pkg::REG_BOOST_FLOW:   boost_flow = d;
      rmt_pkg::REG_SUSTAIN_FLOW: sustain_flow = d;
      rmt_pkg::REG_TARGET:       target = d;
      default: ;
    endcase
  endfunction

  function bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotation-based cosine and sine in Q30; angles past a right angle are folded by pi.
  function void cos_sin(logic [15:0] ang, output longint c, output longint s);
    bit [31:0] a;
    longint z, x, y, nx;
    bit flip;
    a = {ang, 16'h0};
    x = 652032874;
    y = 0;
    flip = 0;
    z = $signed(a);
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      a = a + 32'h80000000;
      z = $signed(a);
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(atan_tab[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(atan_tab[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function logic [24:0] thrust_part(longint f, longint p, longint q);
    longint r;
    r = (f * ((p * q) >>> 30)) >>> 31;
    if (r > 16777215) r = 16777215;
    if (r < -16777215) r = -16777215;
    return r[24:0];
  endfunction

  // Accepted step request: advance the mass and queue the expected result.
  function void note_step(step_req_t r);
    bit [63:0] t, t1, t2, t3, flow, fu, p, dm, stp, sq, mag;
    longint f, diff, span, rd, v, err, cx, sx, cy, sy, cz, sz;
    motor_out_t e;
    t = r.fly_time;
    t1 = ramp_up;
    t2 = t1 + hold;
    t3 = t2 + ramp_down;
    flow = boost_flow;
    if (t < t1) begin
      fu = (64'(boost) * t) / t1;
      f = fu;
    end else if (t < t2) begin
      f = boost;
    end else if (t < t3) begin
      diff = longint'(sustain) - longint'(boost);
      span = t - t2;
      rd = ramp_down;
      f = longint'(boost) + diff * span / rd;
    end else begin
      flow = sustain_flow;
      sq = 0;
      v = r.vel_x; mag = v < 0 ? -v : v; sq += mag * mag;
      v = r.vel_y; mag = v < 0 ? -v : v; sq += mag * mag;
      v = r.vel_z; mag = v < 0 ? -v : v; sq += mag * mag;
      err = longint'(target) - longint'(root_floor(sq));
      if (err > longint'(sustain)) err = sustain;
      if (err < 0) err = 0;
      f = err;
    end
    if (mass_q16 == 0) begin
      f = 0;
      spent_steps++;
    end
    fu = f;
    p = fu * flow;
    stp = r.sim_step;
    dm = (((p >> 32) * stp) << 16) + (((p & 64'hFFFFFFFF) * stp) >> 16);
    mass_q16 = mass_q16 > dm ? mass_q16 - dm : 0;
    cos_sin(r.angle_x, cx, sx);
    cos_sin(r.angle_y, cy, sy);
    cos_sin(r.angle_z, cz, sz);
    e.mass_left = mass_q16[55:16];
    e.thrust_x = thrust_part(f, cx, cy + cz);
    e.thrust_y = thrust_part(f, cx, sy);
    e.thrust_z = thrust_part(f, cx, sz);
    expected_q.push_back(e);
  endfunction

  function void check_result(motor_out_t got);
    motor_out_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: mass_left %0d", got.mass_left);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (got.mass_left !== e.mass_left) begin
      $error("mass_left: expected %0d, got %0d", e.mass_left, got.mass_left);
      errors++;
    end
    if (got.thrust_x !== e.thrust_x) begin
      $error("thrust_x: expected %0d, got %0d", e.thrust_x, got.thrust_x);
      errors++;
    end
    if (got.thrust_y !== e.thrust_y) begin
      $error("thrust_y: expected %0d, got %0d", e.thrust_y, got.thrust_y);
      errors++;
    end
    if (got.thrust_z !== e.thrust_z) begin
      $error("thrust_z: expected %0d, got %0d", e.thrust_z, got.thrust_z);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   cycles = 0;
  int   phases = 0;
  motor_scoreboard board = new();

  rmt_in_if  step_if();
  rmt_out_if res_if();
  rmt_cfg_if cfg_if();

  rocket_motor_thrust_mass_step dut (
    .clk(clk), .rst(rst), .step_in(step_if), .step_out(res_if), .cfg(cfg_if)
  );

  always #5 clk = ~clk;

  // Known levels on every input before the first edge.
  initial begin
    step_if.valid = 1'b0; step_if.sim_step = '0; step_if.fly_time = '0;
    step_if.vel_x = '0; step_if.vel_y = '0; step_if.vel_z = '0;
    step_if.angle_x = '0; step_if.angle_y = '0; step_if.angle_z = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    res_if.ready = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check accepted results and stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready)
        board.check_result('{res_if.mass_left, res_if.thrust_x,
                             res_if.thrust_y, res_if.thrust_z});
      res_if.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_step(step_req_t r);
    if (!calm && $urandom_range(99) < 33) begin
      step_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    step_if.valid <= 1'b1;
    step_if.sim_step <= r.sim_step; step_if.fly_time <= r.fly_time;
    step_if.vel_x <= r.vel_x; step_if.vel_y <= r.vel_y; step_if.vel_z <= r.vel_z;
    step_if.angle_x <= r.angle_x; step_if.angle_y <= r.angle_y;
    step_if.angle_z <= r.angle_z;
    @(posedge clk);
    while (!step_if.ready) @(posedge clk);
    board.note_step(r);
  endtask

  // Hold off until every expected result is in, then let the block drain.
  task automatic drain;
    step_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // One register write; the caller drops valid after the last write of a burst.
  task automatic write_reg(logic [3:0] idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.write_reg(idx, d);
  endtask

  task automatic load_profile(logic [31:0] up, logic [31:0] hd, logic [31:0] dn,
                              logic [31:0] bst, logic [31:0] sus, logic [31:0] bfl,
                              logic [31:0] sfl, logic [31:0] tgt);
    drain();
    write_reg(rmt_pkg::REG_RAMP_UP, up);
    write_reg(rmt_pkg::REG_HOLD, hd);
    write_reg(rmt_pkg::REG_RAMP_DOWN, dn);
    write_reg(rmt_pkg::REG_BOOST, bst);
    write_reg(rmt_pkg::REG_SUSTAIN, sus);
    write_reg(rmt_pkg::REG_BOOST_FLOW, bfl);
    write_reg(rmt_pkg::REG_SUSTAIN_FLOW, sfl);
    write_reg(rmt_pkg::REG_TARGET, tgt);
    cfg_if.valid <= 1'b0;
    phases++;
  endtask

  // Flight time aimed at one of the profile phases, at an edge between them, or fully random.
  function automatic logic [39:0] pick_time();
    bit [63:0] t1, t2, t3;
    t1 = board.ramp_up;
    t2 = t1 + board.hold;
    t3 = t2 + board.ramp_down;
    case ($urandom_range(7))
      0: return t1 == 0 ? 40'd0 : 40'({$urandom, $urandom} % t1);
      1: return 40'(t1 + (board.hold == 0 ? 0 : {$urandom, $urandom} % board.hold));
      2: return 40'(t2 + (board.ramp_down == 0 ? 0 : {$urandom, $urandom} % board.ramp_down));
      3: return 40'(t3 + $urandom_range(0, 100000));
      4: return 40'(t3);
      5: return 40'(t1 + $urandom_range(0, 2) - 1);
      6: return 40'(t2 + $urandom_range(0, 2) - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic step_req_t random_step();
    step_req_t r;
    r.sim_step = ($urandom_range(99) < 3) ? 20'($urandom) : 20'($urandom_range(0, 5000));
    r.fly_time = pick_time();
    r.vel_x = $signed($urandom) >>> $urandom_range(0, 31);
    r.vel_y = $signed($urandom) >>> $urandom_range(0, 31);
    r.vel_z = $signed($urandom) >>> $urandom_range(0, 31);
    r.angle_x = 16'($urandom); r.angle_y = 16'($urandom); r.angle_z = 16'($urandom);
    return r;
  endfunction

  task automatic random_steps(int n);
    repeat (n) send_step(random_step());
  endtask

  function automatic step_req_t mk(logic [19:0] st, logic [39:0] t, int vx, int vy,
                                   int vz, int ax, int ay, int az);
    step_req_t r;
    r.sim_step = st; r.fly_time = t;
    r.vel_x = vx; r.vel_y = vy; r.vel_z = vz;
    r.angle_x = 16'(ax); r.angle_y = 16'(ay); r.angle_z = 16'(az);
    return r;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps under the reset profile.
    load_profile(1000000, 5000000, 1000000, 10000, 2000, 17530000, 17530000, 340000);
    send_step(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk(20'hFFFFF, 500000, 0, 0, 0, 16384, -16384, 16385));
    send_step(mk(1000, 999999, 0, 0, 0, 32767, -32768, -16385));
    send_step(mk(1000, 1000000, 0, 0, 0, -32768, 32767, 8192));
    send_step(mk(1000, 6500000, 0, 0, 0, 4096, -4096, 0));
    send_step(mk(1000, 7000000, 339000, 0, 0, 0, 0, 0));
    send_step(mk(1000, 7000000, 0, 400000, 0, 0, 0, 0));
    send_step(mk(1000, 40'hFFFFFFFFFF, -2147483648, -2147483648, -2147483648, 1, -1, 2));
    send_step(mk(1000, 8000000, 2147483647, 2147483647, 2147483647, 0, 0, 0));
    send_step(mk(1000, 8000000, 100000, -100000, 50000, -20000, 20000, 100));

    // Zero-length ramps and hold: only speed hold remains.
    load_profile(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 64, 64, 32'hFFFFFFFF);
    send_step(mk(100, 0, 0, 0, 0, 16384, 0, 0));
    send_step(mk(100, 5, 1, -1, 1, 0, 16384, -16384));
    random_steps(150);

    // Random profiles; one phase runs without any idling.
    for (int k = 0; k < 6; k++) begin
      load_profile($urandom_range(0, 2000000), $urandom_range(0, 2000000),
                   $urandom_range(1, 2000000), $urandom & 32'hFFFFFF,
                   $urandom & 32'hFFFFFF, $urandom_range(0, 1024),
                   $urandom_range(0, 1024), $urandom >> $urandom_range(0, 12));
      calm = (k == 2);
      random_steps(200);
    end
    calm = 1'b0;

    // Longest profile with full thrust levels.
    load_profile(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 1, 0, 32'hFFFFFFFF);
    random_steps(120);

    // Full flow rates: the propellant runs out and stays spent.
    load_profile(1000, 1000, 1000, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
                 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_steps(150);

    drain();
    $display("Checked %0d step results over %0d register profiles; %0d steps ran spent.",
             board.checked, phases, board.spent_steps);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
